FILE: sv/tcc_pkg.sv
`timescale 1ns / 1ps
// shared types, widths and helpers for the tridiagonal complex cholesky core
// no dependencies; imported by every module of the block
package tcc_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int DATA_W     = 32;
    localparam int PROD_W     = 2 * DATA_W;
    localparam int ACC_W      = PROD_W + 2;
    localparam int SAT_W      = ACC_W + 1;
    localparam int DIV_W      = PROD_W + FRAC_BITS;
    localparam int DIV_CNT_W  = $clog2(DIV_W);
    localparam int MUL_CNT_W  = $clog2(DATA_W);
    localparam int SQRT_REM_W = DATA_W + 2;

    typedef logic signed [DATA_W-1:0] t_fix;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_DIVZ = 2'd1,
        ST_SAT  = 2'd2
    } t_status;

    typedef struct packed {
        logic first_row;
        t_fix diag_re;
        t_fix diag_im;
        t_fix sub_re;
        t_fix sub_im;
    } t_in_item;

    typedef struct packed {
        t_fix    factor_diag_re;
        t_fix    factor_diag_im;
        t_fix    factor_sub_re;
        t_fix    factor_sub_im;
        t_status status;
    } t_out_item;

    typedef enum logic [4:0] {
        S_IDLE, S_DEN0, S_DEN1, S_DENCHK, S_NRE0, S_NRE1, S_DIVRE,
        S_NIM0, S_NIM1, S_DIVIM, S_SQ0, S_SQ1, S_TRE, S_SQ2, S_TIM,
        S_MAG0, S_MAG1, S_ROOT, S_ROOTRE, S_ROOTIM, S_DONE
    } t_state;

    // magnitude of a signed fix value, exact for the most negative code
    function automatic logic [DATA_W-1:0] fix_mag(input t_fix v);
        return v[DATA_W-1] ? DATA_W'(-v) : DATA_W'(v);
    endfunction

    // true when a wide value does not fit the fix range
    function automatic logic fix_ovf(input logic signed [SAT_W-1:0] v);
        return !((&v[SAT_W-1:DATA_W-1]) || !(|v[SAT_W-1:DATA_W-1]));
    endfunction

    // clamp a wide value to the fix range
    function automatic t_fix fix_sat(input logic signed [SAT_W-1:0] v);
        t_fix res;
        if (fix_ovf(v)) begin
            res = v[SAT_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
        end else begin
            res = v[DATA_W-1:0];
        end
        return res;
    endfunction

endpackage

FILE: sv/tcc_mul.sv
`timescale 1ns / 1ps
// bit-serial signed multiplier, one multiplier bit per cycle
// depends on tcc_pkg
module tcc_mul
    import tcc_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  t_fix                     i_a,
    input  t_fix                     i_b,
    output logic                     o_busy,
    output logic                     o_done,
    output logic signed [PROD_W-1:0] o_prod
);

    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [MUL_CNT_W-1:0] r_cnt;
    logic                 r_neg;
    logic [DATA_W-1:0]    r_mcand;
    logic [PROD_W-1:0]    r_p;
    logic [DATA_W:0]      w_sum;

    // shift-add step on the upper half
    assign w_sum = {1'b0, r_p[PROD_W-1:DATA_W]} + (r_p[0] ? {1'b0, r_mcand} : '0);

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_busy = 1'b1;
        end else if (r_busy && r_cnt == MUL_CNT_W'(DATA_W - 1)) begin
            n_busy = 1'b0;
            n_done = 1'b1;
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    // operand and product shift register
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt   <= '0;
            r_neg   <= i_a[DATA_W-1] ^ i_b[DATA_W-1];
            r_mcand <= fix_mag(i_a);
            r_p     <= {{DATA_W{1'b0}}, fix_mag(i_b)};
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            r_p   <= {w_sum, r_p[DATA_W-1:1]};
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_prod = r_neg ? -$signed(r_p) : $signed(r_p);

endmodule

FILE: sv/tcc_div.sv
`timescale 1ns / 1ps
// restoring divider, one quotient bit per cycle, fraction-scaled and saturated
// depends on tcc_pkg
module tcc_div
    import tcc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [PROD_W-1:0] i_num_mag,
    input  logic              i_num_neg,
    input  logic [PROD_W-1:0] i_den,
    output logic              o_busy,
    output logic              o_done,
    output t_fix              o_quot,
    output logic              o_sat
);

    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0]     r_dvd;
    logic [PROD_W-1:0]    r_rem;
    logic [PROD_W-1:0]    r_den;
    logic [DATA_W:0]      r_q;
    logic                 r_ovf;
    logic                 r_neg;
    logic [PROD_W:0]      w_trial;
    logic                 w_ge;
    logic [PROD_W:0]      w_diff;
    logic [DATA_W:0]      w_limit;
    logic                 w_over;
    logic [DATA_W:0]      w_mag;
    logic [DATA_W:0]      w_signed;

    // one remainder step
    assign w_trial = {r_rem, r_dvd[DIV_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_den};
    assign w_diff  = w_trial - {1'b0, r_den};

    // clamp to the signed range on the quotient's side
    assign w_limit  = r_neg ? {2'b01, {(DATA_W-1){1'b0}}} : {2'b00, {(DATA_W-1){1'b1}}};
    assign w_over   = r_ovf || (r_q > w_limit);
    assign w_mag    = w_over ? w_limit : r_q;
    assign w_signed = r_neg ? -w_mag : w_mag;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_busy = 1'b1;
        end else if (r_busy && r_cnt == DIV_CNT_W'(DIV_W - 1)) begin
            n_busy = 1'b0;
            n_done = 1'b1;
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    // dividend shift register, remainder and quotient
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt <= '0;
            r_dvd <= {i_num_mag, {FRAC_BITS{1'b0}}};
            r_rem <= '0;
            r_den <= i_den;
            r_q   <= '0;
            r_ovf <= 1'b0;
            r_neg <= i_num_neg;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            r_dvd <= {r_dvd[DIV_W-2:0], 1'b0};
            r_rem <= w_ge ? w_diff[PROD_W-1:0] : w_trial[PROD_W-1:0];
            r_q   <= {r_q[DATA_W-1:0], w_ge};
            r_ovf <= r_ovf | r_q[DATA_W];
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = w_signed[DATA_W-1:0];
    assign o_sat  = w_over;

endmodule

FILE: sv/tcc_sqrt.sv
`timescale 1ns / 1ps
// digit-by-digit integer square root, two radicand bits per cycle
// depends on tcc_pkg
module tcc_sqrt
    import tcc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [PROD_W-1:0] i_rad,
    output logic              o_busy,
    output logic              o_done,
    output logic [DATA_W-1:0] o_root
);

    logic                    r_busy, n_busy;
    logic                    r_done, n_done;
    logic [MUL_CNT_W-1:0]    r_cnt;
    logic [PROD_W-1:0]       r_rad;
    logic [SQRT_REM_W-1:0]   r_rem;
    logic [DATA_W-1:0]       r_root;
    logic [SQRT_REM_W+1:0]   w_rr;
    logic [SQRT_REM_W+1:0]   w_trial;
    logic                    w_ge;
    logic [SQRT_REM_W+1:0]   w_diff;

    // bring down two bits and try the next root digit
    assign w_rr    = {r_rem, r_rad[PROD_W-1:PROD_W-2]};
    assign w_trial = {2'b00, r_root, 2'b01};
    assign w_ge    = w_rr >= w_trial;
    assign w_diff  = w_rr - w_trial;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_busy = 1'b1;
        end else if (r_busy && r_cnt == MUL_CNT_W'(DATA_W - 1)) begin
            n_busy = 1'b0;
            n_done = 1'b1;
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    // radicand shift register, partial remainder and root
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt  <= '0;
            r_rad  <= i_rad;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_cnt  <= r_cnt + 1'b1;
            r_rad  <= {r_rad[PROD_W-3:0], 2'b00};
            r_rem  <= w_ge ? w_diff[SQRT_REM_W-1:0] : w_rr[SQRT_REM_W-1:0];
            r_root <= {r_root[DATA_W-2:0], w_ge};
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_root = r_root;

endmodule

FILE: sv/tridiagonal_complex_cholesky_core.sv
`timescale 1ns / 1ps
// streaming cholesky factor of a complex symmetric tridiagonal matrix
// depends on tcc_pkg, tcc_mul, tcc_div, tcc_sqrt
//
// usage:
//   input channel i_in_valid / o_in_stall / i_in_item carries one matrix row per
//   item: first_row flag, diagonal entry and the sub-diagonal entry above it.
//   output channel o_out_valid / i_out_stall / o_out_item carries one factor row
//   per item with a status code (ok, division by zero diagonal, saturation).
//   all values are signed Q16.16 per component.
// timing:
//   one item at a time. a first row passes two serial multiplies and three serial
//   square roots; a later row passes eleven serial multiplies, two divisions,
//   three square roots and three steps that use no shared unit, and skips four
//   of the multiplies and both divisions when the previous diagonal is zero. the
//   next item is taken in the cycle after the result is loaded. every multiply,
//   division and square root runs on the shared bit-serial units.
// reset:
//   synchronous active-low i_rst_n clears the sequencer, the output valid and
//   the kept previous factor diagonal (zero).
// stall:
//   a finished item waits in the output register; the next item is taken and
//   computed meanwhile, and the sequencer holds its result until the output
//   register frees up.
module tridiagonal_complex_cholesky_core
    import tcc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    t_state                   r_state, n_state;
    logic                     r_go;
    t_in_item                 r_item;
    t_fix                     r_prev_re, r_prev_im;
    logic signed [ACC_W-1:0]  r_acc;
    logic [PROD_W-1:0]        r_den;
    t_fix                     r_s_re, r_s_im;
    t_fix                     r_t_re, r_t_im;
    logic [DATA_W-1:0]        r_r;
    t_fix                     r_o_re, r_o_im;
    logic                     r_divz, r_sat;
    logic                     r_out_valid;
    t_out_item                r_out;

    logic                     w_accept, w_load;
    logic                     w_mul_state, w_div_state, w_sqrt_state;
    t_fix                     w_mul_a, w_mul_b;
    logic                     mul_busy, mul_done;
    logic signed [PROD_W-1:0] mul_prod;
    logic signed [ACC_W-1:0]  w_prod_ext;
    logic [ACC_W-1:0]         w_acc_mag;
    logic                     div_busy, div_done, div_sat;
    t_fix                     div_quot;
    logic                     sqrt_busy, sqrt_done;
    logic [PROD_W-1:0]        w_rad;
    logic [DATA_W-1:0]        sqrt_root;
    logic signed [SAT_W-1:0]  w_t_re_wide, w_t_im_wide;
    logic signed [DATA_W+2:0] w_u, w_w;

    assign w_accept = i_in_valid && !o_in_stall;
    assign w_load   = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);

    // operand selection for the shared units
    always_comb begin
        w_mul_state  = 1'b1;
        w_div_state  = 1'b0;
        w_sqrt_state = 1'b0;
        w_mul_a      = '0;
        w_mul_b      = '0;
        w_rad        = '0;
        unique case (r_state)
            S_DEN0:   begin w_mul_a = r_prev_re;      w_mul_b = r_prev_re; end
            S_DEN1:   begin w_mul_a = r_prev_im;      w_mul_b = r_prev_im; end
            S_NRE0:   begin w_mul_a = r_item.sub_re;  w_mul_b = r_prev_re; end
            S_NRE1:   begin w_mul_a = r_item.sub_im;  w_mul_b = r_prev_im; end
            S_NIM0:   begin w_mul_a = r_item.sub_im;  w_mul_b = r_prev_re; end
            S_NIM1:   begin w_mul_a = r_item.sub_re;  w_mul_b = r_prev_im; end
            S_SQ0:    begin w_mul_a = r_s_re;         w_mul_b = r_s_re;    end
            S_SQ1:    begin w_mul_a = r_s_im;         w_mul_b = r_s_im;    end
            S_SQ2:    begin w_mul_a = r_s_re;         w_mul_b = r_s_im;    end
            S_MAG0:   begin w_mul_a = r_t_re;         w_mul_b = r_t_re;    end
            S_MAG1:   begin w_mul_a = r_t_im;         w_mul_b = r_t_im;    end
            S_DIVRE, S_DIVIM: begin
                w_mul_state = 1'b0;
                w_div_state = 1'b1;
            end
            S_ROOT: begin
                w_mul_state  = 1'b0;
                w_sqrt_state = 1'b1;
                w_rad        = r_acc[PROD_W-1:0];
            end
            S_ROOTRE: begin
                w_mul_state  = 1'b0;
                w_sqrt_state = 1'b1;
                w_rad        = PROD_W'(w_u[DATA_W+1:0]) << (FRAC_BITS - 1);
            end
            S_ROOTIM: begin
                w_mul_state  = 1'b0;
                w_sqrt_state = 1'b1;
                w_rad        = PROD_W'(w_w[DATA_W+1:0]) << (FRAC_BITS - 1);
            end
            default: w_mul_state = 1'b0;
        endcase
    end

    // wide helpers
    assign w_prod_ext  = ACC_W'(mul_prod);
    assign w_acc_mag   = r_acc[ACC_W-1] ? ACC_W'(-r_acc) : ACC_W'(r_acc);
    assign w_t_re_wide = SAT_W'($signed(r_item.diag_re)) - SAT_W'(r_acc >>> FRAC_BITS);
    assign w_t_im_wide = SAT_W'($signed(r_item.diag_im)) - SAT_W'(r_acc >>> (FRAC_BITS - 1));
    assign w_u = $signed({3'b000, r_r}) + (DATA_W+3)'($signed(r_t_re));
    assign w_w = $signed({3'b000, r_r}) - (DATA_W+3)'($signed(r_t_re));

    tcc_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_go && w_mul_state),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .o_busy  (mul_busy),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    tcc_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (r_go && w_div_state),
        .i_num_mag (w_acc_mag[PROD_W-1:0]),
        .i_num_neg (r_acc[ACC_W-1]),
        .i_den     (r_den),
        .o_busy    (div_busy),
        .o_done    (div_done),
        .o_quot    (div_quot),
        .o_sat     (div_sat)
    );

    tcc_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_go && w_sqrt_state),
        .i_rad   (w_rad),
        .o_busy  (sqrt_busy),
        .o_done  (sqrt_done),
        .o_root  (sqrt_root)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (w_accept) begin
                n_state = i_in_item.first_row ? S_MAG0 : S_DEN0;
            end
            S_DEN0:   if (mul_done) n_state = S_DEN1;
            S_DEN1:   if (mul_done) n_state = S_DENCHK;
            S_DENCHK: n_state = (r_acc == '0) ? S_SQ0 : S_NRE0;
            S_NRE0:   if (mul_done) n_state = S_NRE1;
            S_NRE1:   if (mul_done) n_state = S_DIVRE;
            S_DIVRE:  if (div_done) n_state = S_NIM0;
            S_NIM0:   if (mul_done) n_state = S_NIM1;
            S_NIM1:   if (mul_done) n_state = S_DIVIM;
            S_DIVIM:  if (div_done) n_state = S_SQ0;
            S_SQ0:    if (mul_done) n_state = S_SQ1;
            S_SQ1:    if (mul_done) n_state = S_TRE;
            S_TRE:    n_state = S_SQ2;
            S_SQ2:    if (mul_done) n_state = S_TIM;
            S_TIM:    n_state = S_MAG0;
            S_MAG0:   if (mul_done) n_state = S_MAG1;
            S_MAG1:   if (mul_done) n_state = S_ROOT;
            S_ROOT:   if (sqrt_done) n_state = S_ROOTRE;
            S_ROOTRE: if (sqrt_done) n_state = S_ROOTIM;
            S_ROOTIM: if (sqrt_done) n_state = S_DONE;
            S_DONE:   if (w_load) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // state register and unit start pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_go    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_go    <= (n_state != r_state);
        end
    end

    // kept factor diagonal and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_re   <= '0;
            r_prev_im   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_prev_re   <= r_o_re;
                r_prev_im   <= r_o_im;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= i_in_item;
            r_s_re <= '0;
            r_s_im <= '0;
            r_t_re <= i_in_item.diag_re;
            r_t_im <= i_in_item.diag_im;
            r_divz <= 1'b0;
            r_sat  <= 1'b0;
        end
        // accumulate serial products
        if (mul_done) begin
            unique case (r_state)
                S_DEN1, S_NRE1, S_MAG1: r_acc <= r_acc + w_prod_ext;
                S_NIM1, S_SQ1:          r_acc <= r_acc - w_prod_ext;
                default:                r_acc <= w_prod_ext;
            endcase
        end
        if (r_state == S_DENCHK) begin
            r_den <= r_acc[PROD_W-1:0];
            if (r_acc == '0) r_divz <= 1'b1;
        end
        if (div_done) begin
            if (r_state == S_DIVRE) r_s_re <= div_quot;
            else r_s_im <= div_quot;
            if (div_sat) r_sat <= 1'b1;
        end
        if (r_state == S_TRE) begin
            r_t_re <= fix_sat(w_t_re_wide);
            if (fix_ovf(w_t_re_wide)) r_sat <= 1'b1;
        end
        if (r_state == S_TIM) begin
            r_t_im <= fix_sat(w_t_im_wide);
            if (fix_ovf(w_t_im_wide)) r_sat <= 1'b1;
        end
        if (sqrt_done) begin
            unique case (r_state)
                S_ROOT:   r_r <= sqrt_root;
                S_ROOTRE: r_o_re <= t_fix'(sqrt_root);
                default:  r_o_im <= r_t_im[DATA_W-1] ? -t_fix'(sqrt_root) : t_fix'(sqrt_root);
            endcase
        end
        if (w_load) begin
            r_out.factor_diag_re <= r_o_re;
            r_out.factor_diag_im <= r_o_im;
            r_out.factor_sub_re  <= r_s_re;
            r_out.factor_sub_im  <= r_s_im;
            r_out.status         <= r_divz ? ST_DIVZ : (r_sat ? ST_SAT : ST_OK);
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // only one shared unit runs at a time
    a_one_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({mul_busy, div_busy, sqrt_busy}))
        else $error("more than one arithmetic unit busy");

    // a zero previous diagonal leaves the sub factor at zero
    a_divz_sub: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.status == ST_DIVZ) |->
        (o_out_item.factor_sub_re == '0 && o_out_item.factor_sub_im == '0))
        else $error("sub factor nonzero on division by zero");

    // principal root has a nonnegative real part
    a_root_re: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_out_item.factor_diag_re[DATA_W-1])
        else $error("negative real part of factor diagonal");

    // a new item enters only after the previous result left the sequencer
    a_load_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> (r_state == S_IDLE))
        else $error("sequencer did not return to idle after result");

endmodule
